[hdl/assert_macros.svh]
// assertion macros for the rtl files, included by the gesture core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on clk, off during rst
`define ASSERT_SAME(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");

// next-cycle implication, checked on clk, off during rst
`define ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

[hdl/kgd_pkg.sv]
// types, codes, constants and decode tables of the knob gesture block
`default_nettype none

package kgd_pkg;

  // counter width default and reset values
  localparam int unsigned COUNT_WIDTH_DEF = 16;
  localparam int unsigned CNT_RESET       = 501;
  localparam int unsigned TIMEOUT_RESET   = 300;
  localparam int unsigned BRIGHT_RESET    = 8;
  localparam int unsigned PARK_MARGIN     = 10;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BRIGHT  = 2'd1;

  // event kinds
  localparam logic [1:0] EV_TICK    = 2'd0;
  localparam logic [1:0] EV_PRESS   = 2'd1;
  localparam logic [1:0] EV_RELEASE = 2'd2;
  localparam logic [1:0] EV_ROTATE  = 2'd3;

  // knob codes
  localparam logic [1:0] KNOB_NONE  = 2'd0;
  localparam logic [1:0] KNOB_BAD   = 2'd3;

  // gesture states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ROT   = 3'd1;
  localparam logic [2:0] ST_PRS   = 3'd2;
  localparam logic [2:0] ST_REL   = 3'd3;
  localparam logic [2:0] ST_PHOLD = 3'd4;
  localparam logic [2:0] ST_RHOLD = 3'd5;

  typedef struct packed {
    logic [1:0]        action;
    logic [1:0]        knob;
    logic signed [7:0] rotate_delta;
  } evt_t;

  typedef struct packed {
    logic              accepted;
    logic [2:0]        gesture_state;
    logic [1:0]        active_knob;
    logic              press_fire;
    logic              rotate_fire;
    logic signed [7:0] rotate_amount;
    logic              brightness_write;
    logic [3:0]        brightness_level;
    logic              timeout_pulse;
  } res_t;

  // actions picked by the gesture table
  typedef struct packed {
    logic cnt;
    logic press;
    logic rot;
    logic forget;
    logic wake;
  } act_t;

  localparam act_t ACT_NONE = '{cnt: 1'b0, press: 1'b0, rot: 1'b0, forget: 1'b0, wake: 1'b0};

  // next gesture state; codes above the last state behave as idle
  function automatic logic [2:0] next_state(input logic [2:0] st, input logic [1:0] ev);
    logic [2:0] ns;
    ns = ST_IDLE;
    case (st)
      ST_ROT: begin
        ns = (ev == EV_TICK) ? ST_IDLE : ST_ROT;
      end
      ST_PRS: begin
        case (ev)
          EV_TICK:    ns = ST_PHOLD;
          EV_RELEASE: ns = ST_REL;
          default:    ns = ST_PRS;
        endcase
      end
      ST_REL: begin
        case (ev)
          EV_TICK:  ns = ST_RHOLD;
          EV_PRESS: ns = ST_PRS;
          default:  ns = ST_REL;
        endcase
      end
      ST_PHOLD: begin
        ns = (ev == EV_RELEASE) ? ST_RHOLD : ST_PHOLD;
      end
      ST_RHOLD: begin
        ns = (ev == EV_TICK) ? ST_IDLE : ST_RHOLD;
      end
      default: begin
        case (ev)
          EV_PRESS:  ns = ST_PRS;
          EV_ROTATE: ns = ST_ROT;
          default:   ns = ST_IDLE;
        endcase
      end
    endcase
    return ns;
  endfunction

  // action set for a state and event
  function automatic act_t actions(input logic [2:0] st, input logic [1:0] ev);
    act_t a;
    a = ACT_NONE;
    case (st)
      ST_ROT: begin
        a.forget = (ev == EV_TICK);
        a.rot    = (ev == EV_ROTATE);
      end
      ST_REL:   a.press  = (ev == EV_TICK);
      ST_PHOLD: a.press  = (ev == EV_RELEASE);
      ST_RHOLD: a.forget = (ev == EV_TICK);
      ST_PRS:   a = ACT_NONE;
      default: begin
        a.cnt    = (ev == EV_TICK);
        a.wake   = (ev == EV_PRESS) || (ev == EV_ROTATE);
        a.forget = (ev == EV_RELEASE);
        a.rot    = (ev == EV_ROTATE);
      end
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

[hdl/kgd_if.sv]
// channel interfaces: knob events, results and configuration writes
`default_nettype none

interface kgd_evt_if import kgd_pkg::*;;
  logic valid;
  logic ready;
  evt_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface kgd_res_if import kgd_pkg::*;;
  logic valid;
  logic ready;
  res_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface kgd_cfg_if import kgd_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[hdl/knob_gesture_fsm_with_dimming_core.sv]
// knob gesture state machine with inactivity dimming, top level
//
//   channel  dir  handshake          payload
//   cfg      in   cfg.valid/ready    index (2b), data (16b)
//   evt      in   evt.valid/ready    action, knob, rotate_delta
//   res      out  res.valid/ready    accepted .. timeout_pulse
//
// the gesture table and the idle counter update are combinational between
// the state registers and the result register.
// a two-entry result buffer (output register plus skid) lets a new event in
// while a result waits; evt.ready drops only when both entries are full.
// rst (synchronous) sets state, counter and registers to reset values and
// empties both result entries. cfg.ready is always high.
`default_nettype none
`include "assert_macros.svh"

module knob_gesture_fsm_with_dimming_core import kgd_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  kgd_cfg_if.sink   cfg,
  kgd_evt_if.sink   evt,
  kgd_res_if.source res
);

  localparam int unsigned EXT_W = ((COUNT_WIDTH > 16) ? COUNT_WIDTH : 16) + 1;

  // configuration registers
  logic [15:0] timeout;
  logic [3:0]  full_bright;

  // gesture state
  logic [2:0]             gst;
  logic [1:0]             locked_knob;
  logic [COUNT_WIDTH-1:0] idle_count;

  // result buffer
  logic out_valid;
  res_t out_data;
  logic skid_valid;
  res_t skid_data;

  logic evt_acc;
  logic pop;

  // per-event combinational work
  logic [1:0]             knob_in;
  logic [1:0]             lock_eff;
  logic                   drop;
  act_t                   acts;
  logic [2:0]             gst_next;
  logic [1:0]             locked_next;
  logic [COUNT_WIDTH-1:0] idle_count_next;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic [EXT_W-1:0]       cnt_ext;
  logic [EXT_W-1:0]       t_ext;
  logic [EXT_W-1:0]       park_ext;
  logic [EXT_W-1:0]       max_ext;
  logic [EXT_W-1:0]       dim_ext;
  res_t                   res_new;

  assign cfg.ready = 1'b1;
  assign evt.ready = !skid_valid;
  assign evt_acc   = evt.valid && !skid_valid;
  assign pop       = out_valid && res.ready;
  assign res.valid = out_valid;
  assign res.data  = out_data;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout     <= 16'(TIMEOUT_RESET);
      full_bright <= 4'(BRIGHT_RESET);
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_TIMEOUT: timeout     <= cfg.data;
        CFG_BRIGHT:  full_bright <= cfg.data[3:0];
        default:     ;
      endcase
    end
  end

  // knob lock and drop decision
  always_comb begin
    knob_in  = (evt.data.knob == KNOB_BAD) ? KNOB_NONE : evt.data.knob;
    lock_eff = (locked_knob == KNOB_NONE) ? knob_in : locked_knob;
    drop     = (lock_eff != knob_in) && (knob_in != KNOB_NONE);
    acts     = actions(gst, evt.data.action);
    gst_next = next_state(gst, evt.data.action);
  end

  // idle counter, timeout and dimming ramp
  always_comb begin
    cnt_inc  = (&idle_count) ? idle_count : idle_count + 1'b1;
    cnt_ext  = EXT_W'(cnt_inc);
    t_ext    = EXT_W'(timeout);
    park_ext = t_ext + EXT_W'(PARK_MARGIN);
    max_ext  = EXT_W'({COUNT_WIDTH{1'b1}});
    dim_ext  = park_ext - cnt_ext;

    idle_count_next = idle_count;
    res_new         = '0;
    res_new.accepted      = !drop;
    res_new.gesture_state = drop ? gst : gst_next;

    if (!drop) begin
      res_new.press_fire  = acts.press;
      res_new.rotate_fire = acts.rot;
      if (acts.rot) begin
        res_new.rotate_amount = evt.data.rotate_delta;
      end
      if (acts.press || acts.rot) begin
        res_new.active_knob = lock_eff;
      end
      if (acts.wake) begin
        idle_count_next          = '0;
        res_new.brightness_write = 1'b1;
        res_new.brightness_level = full_bright;
      end
      if (acts.cnt) begin
        idle_count_next = cnt_inc;
        if (cnt_ext >= t_ext) begin
          res_new.timeout_pulse = (cnt_ext == t_ext);
          if (cnt_ext > park_ext) begin
            idle_count_next = (park_ext > max_ext) ? {COUNT_WIDTH{1'b1}}
                                                   : park_ext[COUNT_WIDTH-1:0];
          end else if (dim_ext <= EXT_W'(full_bright)) begin
            res_new.brightness_write = 1'b1;
            res_new.brightness_level = dim_ext[3:0];
          end
        end
      end
    end

    locked_next = (acts.forget) ? KNOB_NONE : lock_eff;
  end

  // state registers, updated on every event that is not dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      gst         <= ST_IDLE;
      locked_knob <= KNOB_NONE;
      idle_count  <= COUNT_WIDTH'(CNT_RESET);
    end else if (evt_acc && !drop) begin
      gst         <= gst_next;
      locked_knob <= locked_next;
      idle_count  <= idle_count_next;
    end
  end

  // result register and skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= evt_acc;
      end else begin
        out_valid  <= evt_acc;
      end
    end else if (evt_acc) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      if (skid_valid) begin
        out_data  <= skid_data;
        skid_data <= res_new;
      end else begin
        out_data  <= res_new;
      end
    end else if (evt_acc) begin
      skid_data <= res_new;
    end
  end

  // checks
  `ASSERT_SAME(a_skid_behind_out, skid_valid, out_valid)
  `ASSERT_NEXT(a_drop_keeps_state, evt_acc && drop,
               $stable(gst) && $stable(locked_knob) && $stable(idle_count))
  `ASSERT_NEXT(a_pulse_at_timeout, evt_acc && res_new.timeout_pulse,
               EXT_W'(idle_count) == EXT_W'(timeout))
  `ASSERT_SAME(a_single_fire, evt_acc, !(res_new.press_fire && res_new.rotate_fire))

endmodule

`default_nettype wire

[sim/tb_knob_gesture_fsm_with_dimming_core.sv]
// self-checking testbench for the knob gesture core with inactivity dimming
`timescale 1ns / 1ps

module tb_knob_gesture_fsm_with_dimming_core;
  import kgd_pkg::*;

  localparam longint unsigned CNT_MAX      = (64'd1 << COUNT_WIDTH_DEF) - 1;
  localparam int              SETTLE_CYC   = 6;
  localparam int              HOLD_CYC     = 60;
  localparam int              RAND_EVENTS  = 100;
  localparam int              BURST_EVENTS = 40;
  localparam int              RUN_LIMIT_NS = 2_000_000;

  // register indexes past the last implemented register
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  // action bits of the gesture table
  localparam logic [4:0] DO_NONE   = 5'b00000;
  localparam logic [4:0] DO_COUNT  = 5'b00001;
  localparam logic [4:0] DO_PRESS  = 5'b00010;
  localparam logic [4:0] DO_ROTATE = 5'b00100;
  localparam logic [4:0] DO_FORGET = 5'b01000;
  localparam logic [4:0] DO_WAKE   = 5'b10000;

  localparam logic [1:0] KNOB_LEFT  = 2'd1;
  localparam logic [1:0] KNOB_RIGHT = 2'd2;

  // next gesture state by [state][event]
  localparam logic [2:0] GEST_NEXT [6][4] = '{
    '{ST_IDLE,  ST_PRS,   ST_IDLE,  ST_ROT},
    '{ST_IDLE,  ST_ROT,   ST_ROT,   ST_ROT},
    '{ST_PHOLD, ST_PRS,   ST_REL,   ST_PRS},
    '{ST_RHOLD, ST_PRS,   ST_REL,   ST_REL},
    '{ST_PHOLD, ST_PHOLD, ST_RHOLD, ST_PHOLD},
    '{ST_IDLE,  ST_RHOLD, ST_RHOLD, ST_RHOLD}
  };

  // actions by [state][event]
  localparam logic [4:0] GEST_ACTS [6][4] = '{
    '{DO_COUNT,  DO_WAKE, DO_FORGET, DO_ROTATE | DO_WAKE},
    '{DO_FORGET, DO_NONE, DO_NONE,   DO_ROTATE},
    '{DO_NONE,   DO_NONE, DO_NONE,   DO_NONE},
    '{DO_PRESS,  DO_NONE, DO_NONE,   DO_NONE},
    '{DO_NONE,   DO_NONE, DO_PRESS,  DO_NONE},
    '{DO_FORGET, DO_NONE, DO_NONE,   DO_NONE}
  };

  logic clk;
  logic rst;

  kgd_cfg_if cfg_ch();
  kgd_evt_if evt_ch();
  kgd_res_if res_ch();

  knob_gesture_fsm_with_dimming_core u_dut (
    .clk(clk),
    .rst(rst),
    .cfg(cfg_ch),
    .evt(evt_ch),
    .res(res_ch)
  );

  // predicted block state and registers
  logic [2:0]      gest_state;
  logic [1:0]      lock_knob;
  longint unsigned idle_cnt;
  longint unsigned timeout_val;
  logic [3:0]      full_level;

  res_t pending_results[$];

  // run control and tallies
  bit gaps_on;
  bit noise_on;
  bit quiet;
  bit hold_req;
  int errors;
  int n_events;
  int n_dropped;
  int n_press;
  int n_rotate;
  int n_pulse;
  int n_bright;
  int n_cfg;

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // watchdog
  initial begin
    #(RUN_LIMIT_NS);
    $display("TEST FAILED");
    $finish;
  end

  // expected result of one knob event, advancing the predicted state
  function automatic res_t predict_gesture(evt_t e);
    logic [1:0]      k;
    logic [2:0]      cur;
    logic [4:0]      acts;
    longint unsigned lim;
    longint unsigned park;
    res_t            r;
    r = '0;
    k = (e.knob == KNOB_BAD) ? KNOB_NONE : e.knob;
    if (lock_knob == KNOB_NONE) lock_knob = k;
    // the other knob is dropped while a lock is held
    if (k != KNOB_NONE && k != lock_knob) begin
      r.gesture_state = gest_state;
      return r;
    end
    cur = (gest_state > ST_RHOLD) ? ST_IDLE : gest_state;
    acts = GEST_ACTS[cur][e.action];
    gest_state = GEST_NEXT[cur][e.action];
    r.accepted = 1'b1;
    r.gesture_state = gest_state;
    r.press_fire = ((acts & DO_PRESS) != DO_NONE);
    if ((acts & DO_ROTATE) != DO_NONE) begin
      r.rotate_fire = 1'b1;
      r.rotate_amount = e.rotate_delta;
    end
    if (r.press_fire || r.rotate_fire) r.active_knob = lock_knob;
    // activity restores full brightness
    if ((acts & DO_WAKE) != DO_NONE) begin
      idle_cnt = 0;
      r.brightness_write = 1'b1;
      r.brightness_level = full_level;
    end
    // idle tick: count, pulse on the timeout, ramp down, then park
    if ((acts & DO_COUNT) != DO_NONE) begin
      lim = timeout_val;
      if (idle_cnt < CNT_MAX) idle_cnt++;
      if (idle_cnt >= lim) begin
        if (idle_cnt == lim) r.timeout_pulse = 1'b1;
        if (idle_cnt > lim + PARK_MARGIN) begin
          park = lim + PARK_MARGIN;
          idle_cnt = (park > CNT_MAX) ? CNT_MAX : park;
        end else if (lim + PARK_MARGIN - idle_cnt <= full_level) begin
          r.brightness_write = 1'b1;
          r.brightness_level = 4'(lim + PARK_MARGIN - idle_cnt);
        end
      end
    end
    if ((acts & DO_FORGET) != DO_NONE) lock_knob = KNOB_NONE;
    return r;
  endfunction

  // one event transaction, with an optional idle burst before it
  task automatic send_event(evt_t e);
    res_t r;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      evt_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    evt_ch.valid <= 1'b1;
    evt_ch.data  <= e;
    do @(posedge clk); while (evt_ch.ready !== 1'b1);
    r = predict_gesture(e);
    pending_results.push_back(r);
    if (r.accepted) n_events++;
    else n_dropped++;
    n_press  += r.press_fire;
    n_rotate += r.rotate_fire;
    n_pulse  += r.timeout_pulse;
    n_bright += r.brightness_write;
  endtask

  // event of a given kind, sometimes preceded by a stray event
  task automatic poke(logic [1:0] act, logic [1:0] k);
    evt_t e;
    if (noise_on && $urandom_range(0, 9) == 0) begin
      e = 12'($urandom);
      send_event(e);
    end
    e.action = act;
    e.knob = k;
    e.rotate_delta = 8'($urandom);
    send_event(e);
  endtask

  task automatic send_fixed(logic [1:0] act, logic [1:0] k, logic [7:0] d);
    evt_t e;
    e.action = act;
    e.knob = k;
    e.rotate_delta = d;
    send_event(e);
  endtask

  // stop offering events and let every outstanding result come back
  task automatic wait_idle();
    evt_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic cfg_handshake();
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    n_cfg++;
  endtask

  // write both registers, optionally also the unused indexes
  task automatic cfg_update(logic [15:0] t, logic [3:0] b, bit spare);
    logic [15:0] junk;
    junk = 16'($urandom);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= CFG_TIMEOUT;
    cfg_ch.data  <= t;
    cfg_handshake();
    timeout_val = t;
    // upper bits of the brightness word are dropped by the block
    cfg_ch.index <= CFG_BRIGHT;
    cfg_ch.data  <= {junk[15:4], b};
    cfg_handshake();
    full_level = b;
    if (spare) begin
      cfg_ch.index <= CFG_SPARE_A;
      cfg_ch.data  <= junk;
      cfg_handshake();
      cfg_ch.index <= CFG_SPARE_B;
      cfg_ch.data  <= ~junk;
      cfg_handshake();
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // one gesture with random content, or a short run of random events
  task automatic random_gesture();
    logic [1:0] k;
    k = $urandom_range(0, 1) ? KNOB_LEFT : KNOB_RIGHT;
    if ($urandom_range(0, 7) == 0) k = $urandom_range(0, 1) ? KNOB_NONE : KNOB_BAD;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        poke(EV_PRESS, k);
        repeat ($urandom_range(0, 2)) poke($urandom_range(0, 1) ? EV_ROTATE : EV_PRESS, k);
        repeat ($urandom_range(0, 2)) poke(EV_TICK, k);
        poke(EV_RELEASE, k);
        repeat ($urandom_range(1, 3)) poke(EV_TICK, k);
      end
      3, 4: begin
        repeat ($urandom_range(1, 4)) poke(EV_ROTATE, k);
        poke(EV_TICK, k);
      end
      5, 6: begin
        repeat ($urandom_range(1, 8)) poke(EV_TICK, $urandom_range(0, 1) ? k : KNOB_NONE);
      end
      7: begin
        poke(EV_PRESS, k);
        poke(EV_RELEASE, k);
        poke(EV_PRESS, k);
        poke(EV_RELEASE, k);
        poke(EV_TICK, k);
        poke(EV_TICK, k);
      end
      default: begin
        repeat ($urandom_range(1, 4)) poke(2'($urandom), 2'($urandom));
      end
    endcase
  endtask

  // a fixed walk through the gesture table, knob locking and odd knob codes
  task automatic test_gesture_paths();
    send_fixed(EV_TICK, KNOB_NONE, 8'h00);
    send_fixed(EV_ROTATE, KNOB_NONE, 8'h80);
    send_fixed(EV_ROTATE, KNOB_LEFT, 8'h7F);
    send_fixed(EV_ROTATE, KNOB_RIGHT, 8'h01);
    send_fixed(EV_PRESS, KNOB_BAD, 8'hFF);
    send_fixed(EV_TICK, KNOB_LEFT, 8'h00);
    send_fixed(EV_PRESS, KNOB_RIGHT, 8'h00);
    send_fixed(EV_ROTATE, KNOB_LEFT, 8'h33);
    send_fixed(EV_TICK, KNOB_RIGHT, 8'h00);
    send_fixed(EV_ROTATE, KNOB_RIGHT, 8'h12);
    send_fixed(EV_RELEASE, KNOB_RIGHT, 8'h00);
    send_fixed(EV_PRESS, KNOB_NONE, 8'h00);
    send_fixed(EV_TICK, KNOB_RIGHT, 8'h00);
    send_fixed(EV_PRESS, KNOB_LEFT, 8'h00);
    send_fixed(EV_RELEASE, KNOB_LEFT, 8'h00);
    send_fixed(EV_PRESS, KNOB_LEFT, 8'h00);
    send_fixed(EV_RELEASE, KNOB_LEFT, 8'h00);
    send_fixed(EV_ROTATE, KNOB_LEFT, 8'h44);
    send_fixed(EV_TICK, KNOB_LEFT, 8'h00);
    send_fixed(EV_RELEASE, KNOB_RIGHT, 8'h00);
    send_fixed(EV_TICK, KNOB_BAD, 8'h00);
    send_fixed(EV_RELEASE, KNOB_LEFT, 8'h00);
    send_fixed(EV_ROTATE, KNOB_RIGHT, 8'h55);
    send_fixed(EV_ROTATE, KNOB_RIGHT, 8'hAA);
    send_fixed(EV_TICK, KNOB_RIGHT, 8'h00);
  endtask

  // write the registers, wake, then tick toward the timeout, the ramp and the parked count
  task automatic dim_cycle(logic [15:0] t, logic [3:0] b, int ticks, bit spare);
    wait_idle();
    cfg_update(t, b, spare);
    send_fixed(EV_PRESS, KNOB_NONE, 8'h00);
    send_fixed(EV_RELEASE, KNOB_NONE, 8'h00);
    send_fixed(EV_TICK, KNOB_NONE, 8'h00);
    send_fixed(EV_TICK, KNOB_NONE, 8'h00);
    repeat (ticks) send_fixed(EV_TICK, KNOB_NONE, 8'($urandom));
  endtask

  task automatic test_dimming_ramp();
    dim_cycle(16'd5, 4'd15, 22, 1'b1);
    dim_cycle(16'd1, 4'd0, 14, 1'b0);
    dim_cycle(16'd1, 4'd15, 16, 1'b0);
    dim_cycle(16'd12, 4'd7, 26, 1'b1);
    dim_cycle(16'd65000, 4'd15, 8, 1'b0);
    dim_cycle(16'd3, 4'd9, 16, 1'b0);
  endtask

  // result side holds off while events keep coming, so the input stalls
  task automatic test_output_backpressure();
    gaps_on = 1'b0;
    hold_req = 1'b1;
    repeat (16) random_gesture();
    gaps_on = 1'b1;
  endtask

  // random gestures in segments, each with its own register setting
  task automatic test_random_gestures();
    int target;
    int seg_end;
    target = n_events + RAND_EVENTS;
    noise_on = 1'b1;
    while (n_events < target) begin
      wait_idle();
      case ($urandom_range(0, 7))
        0:       cfg_update(16'd300, 4'($urandom), 1'b0);
        1:       cfg_update(16'd65000, 4'($urandom), 1'b1);
        default: cfg_update(16'($urandom_range(1, 20)), 4'($urandom), 1'b0);
      endcase
      gaps_on = ($urandom_range(0, 3) != 0);
      seg_end = n_events + $urandom_range(40, 80);
      while (n_events < seg_end && n_events < target) random_gesture();
    end
    gaps_on = 1'b1;
  endtask

  // closing stretch at full rate on both sides
  task automatic test_back_to_back();
    int target;
    wait_idle();
    cfg_update(16'd4, 4'd6, 1'b0);
    quiet = 1'b1;
    gaps_on = 1'b0;
    target = n_events + BURST_EVENTS;
    while (n_events < target) random_gesture();
  endtask

  // result acceptor: random stall bursts, a long hold on request
  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYC;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else if (quiet) begin
        res_ch.ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        res_ch.ready <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 5) - 1;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // compare each result transaction with the oldest prediction
  always @(posedge clk) begin : check_results
    res_t want;
    if (!rst && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, res_ch.data);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("accepted", want.accepted, res_ch.data.accepted);
        check_field("gesture_state", want.gesture_state, res_ch.data.gesture_state);
        check_field("active_knob", want.active_knob, res_ch.data.active_knob);
        check_field("press_fire", want.press_fire, res_ch.data.press_fire);
        check_field("rotate_fire", want.rotate_fire, res_ch.data.rotate_fire);
        check_field("rotate_amount", want.rotate_amount, res_ch.data.rotate_amount);
        check_field("brightness_write", want.brightness_write, res_ch.data.brightness_write);
        check_field("brightness_level", want.brightness_level, res_ch.data.brightness_level);
        check_field("timeout_pulse", want.timeout_pulse, res_ch.data.timeout_pulse);
      end
    end
  end

  // reset, test sequence, end of run
  initial begin
    rst <= 1'b1;
    evt_ch.valid <= 1'b0;
    evt_ch.data  <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= CFG_TIMEOUT;
    cfg_ch.data  <= '0;
    gest_state  = ST_IDLE;
    lock_knob   = KNOB_NONE;
    idle_cnt    = CNT_RESET;
    timeout_val = TIMEOUT_RESET;
    full_level  = BRIGHT_RESET;
    gaps_on  = 1'b1;
    noise_on = 1'b0;
    quiet    = 1'b0;
    hold_req = 1'b0;
    errors   = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_gesture_paths();
    test_dimming_ramp();
    test_output_backpressure();
    test_random_gestures();
    test_back_to_back();
    wait_idle();

    $display("covered %0d accepted and %0d dropped events, %0d presses and %0d rotations passed on",
             n_events, n_dropped, n_press, n_rotate);
    $display("%0d timeout pulses, %0d brightness writes, %0d register writes",
             n_pulse, n_bright, n_cfg);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hdl
hdl/kgd_pkg.sv
hdl/kgd_if.sv
hdl/knob_gesture_fsm_with_dimming_core.sv
sim/tb_knob_gesture_fsm_with_dimming_core.sv
